// ----- src/scd_pkg.sv -----
// scd_pkg: shared types, codes and constants of the serial-command LED dimmer.
// No dependencies; imported by every module under src except scd_fifo.
package scd_pkg;

    // Field widths
    localparam int PCT_W  = 7;
    localparam int STEP_W = 7;
    localparam int LOCK_W = 10;
    localparam int CHAR_W = 8;
    localparam int CFG_W  = 10;
    localparam int CFG_IDX_W = 2;

    // Parameter defaults
    localparam int DEF_MAX_LINE_CHARS = 15;
    localparam int DEF_DUTY_BITS      = 10;
    localparam int CMD_FIFO_DEPTH     = 4;
    localparam int OUT_FIFO_DEPTH     = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS  = 2'd2;

    // Register reset values
    localparam logic [STEP_W-1:0] SERIAL_STEP_RST = 7'd10;
    localparam logic [STEP_W-1:0] BUTTON_STEP_RST = 7'd5;
    localparam logic [LOCK_W-1:0] LOCKOUT_RST     = 10'd200;

    // Level limits
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] LEVEL_RST = 7'd50;
    localparam logic [PCT_W-1:0] DIGIT_SAT = 7'd101;
    localparam logic [LOCK_W-1:0] SINCE_SAT = 10'd1023;

    // Characters (letters compared after folding to lower case)
    localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;
    localparam logic [CHAR_W-1:0] CH_CASE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LOW_U  = 8'h75;
    localparam logic [CHAR_W-1:0] CH_LOW_D  = 8'h64;
    localparam logic [CHAR_W-1:0] CH_LOW_M  = 8'h6d;
    localparam logic [CHAR_W-1:0] CH_LOW_N  = 8'h6e;

    // Command opcodes from front to back
    localparam logic [1:0] CMD_KEEP = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_SUB  = 2'd2;
    localparam logic [1:0] CMD_SET  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [STEP_W-1:0] amount;
        logic              last;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    // Gamma 2.2 curve at full scale 1023
    localparam int GAMMA_SCALE = 1023;
    localparam int PCT_ENTRIES = 101;
    localparam logic [9:0] GAMMA_ROM [0:PCT_ENTRIES-1] = '{
        10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd1,   10'd2,   10'd2,
        10'd3,   10'd5,   10'd6,   10'd7,   10'd9,   10'd11,  10'd13,  10'd15,
        10'd18,  10'd20,  10'd23,  10'd26,  10'd29,  10'd33,  10'd36,  10'd40,
        10'd44,  10'd48,  10'd52,  10'd57,  10'd62,  10'd67,  10'd72,  10'd77,
        10'd83,  10'd89,  10'd95,  10'd101, 10'd108, 10'd114, 10'd121, 10'd128,
        10'd136, 10'd143, 10'd151, 10'd159, 10'd168, 10'd176, 10'd185, 10'd194,
        10'd203, 10'd212, 10'd222, 10'd232, 10'd242, 10'd253, 10'd263, 10'd274,
        10'd285, 10'd297, 10'd308, 10'd320, 10'd332, 10'd344, 10'd357, 10'd370,
        10'd383, 10'd396, 10'd410, 10'd423, 10'd437, 10'd452, 10'd466, 10'd481,
        10'd496, 10'd511, 10'd527, 10'd543, 10'd559, 10'd575, 10'd592, 10'd609,
        10'd626, 10'd643, 10'd661, 10'd678, 10'd697, 10'd715, 10'd734, 10'd753,
        10'd772, 10'd791, 10'd811, 10'd831, 10'd851, 10'd872, 10'd892, 10'd913,
        10'd935, 10'd956, 10'd978, 10'd1000, 10'd1023
    };

endpackage

// ----- src/serial_command_led_dimmer_top.sv -----
// serial_command_led_dimmer_top: serial/button LED dimmer with linear and gamma duty.
// Depends on scd_pkg, scd_fifo, scd_front and scd_back.
//
//   channel   handshake               payload
//   items     push / full             i_operation, i_char_code, i_up_pressed, i_down_pressed
//   results   empty / pop             o_brightness_percent, o_linear_duty, o_gamma_duty,
//                                     o_last_of_run
//   config    i_cfg_we (no wait)      i_cfg_idx, i_cfg_wdata
//
// The front takes one item per cycle while full is low; a tick that fires both buttons holds
// full for one extra cycle while its second command enters the command queue.
// The back applies one command per cycle while the result queue has room; an item passes
// the command queue, level register and result queue, and leaves at one per cycle of pop.
// Synchronous active-low reset; no clearing pass. Full also rises when the command queue
// has fewer than two free slots, so a stall on pop backs up through both queues.
module serial_command_led_dimmer_top #(
    parameter int MAX_LINE_CHARS = scd_pkg::DEF_MAX_LINE_CHARS,
    parameter int DUTY_BITS      = scd_pkg::DEF_DUTY_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scd_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_operation,
    input  logic [scd_pkg::CHAR_W-1:0]      i_char_code,
    input  logic                            i_up_pressed,
    input  logic                            i_down_pressed,
    output logic                            empty,
    input  logic                            pop,
    output logic [scd_pkg::PCT_W-1:0]       o_brightness_percent,
    output logic [DUTY_BITS-1:0]            o_linear_duty,
    output logic [DUTY_BITS-1:0]            o_gamma_duty,
    output logic                            o_last_of_run
);
    import scd_pkg::*;

    localparam int RES_W  = PCT_W + 2 * DUTY_BITS + 1;
    localparam int CCNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    logic              cmd_wr, cmd_rd, cmd_empty;
    t_cmd              cmd_in, cmd_out;
    logic [CCNT_W-1:0] cmd_count;
    logic              cmd_room2;

    logic                 res_wr, res_full;
    logic [PCT_W-1:0]     res_pct;
    logic [DUTY_BITS-1:0] res_lin, res_gamma;
    logic                 res_last;
    logic [RES_W-1:0]     res_in, res_out;

    assign cmd_room2 = (cmd_count <= CCNT_W'(CMD_FIFO_DEPTH - 2));

    // Front: classify items into commands
    scd_front #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .o_full         (full),
        .i_operation    (i_operation),
        .i_char_code    (i_char_code),
        .i_up_pressed   (i_up_pressed),
        .i_down_pressed (i_down_pressed),
        .i_cmd_room2    (cmd_room2),
        .o_cmd_wr       (cmd_wr),
        .o_cmd          (cmd_in)
    );

    // Command queue between front and back
    scd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_wr),
        .i_wr_data (cmd_in),
        .i_rd      (cmd_rd),
        .o_rd_data (cmd_out),
        .o_empty   (cmd_empty),
        .o_full    (),
        .o_count   (cmd_count)
    );

    // Back: level update and duty lookup
    scd_back #(
        .DUTY_BITS (DUTY_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_rd    (cmd_rd),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_pct       (res_pct),
        .o_lin       (res_lin),
        .o_gamma     (res_gamma),
        .o_last      (res_last)
    );

    // Result queue toward the output ports
    assign res_in = {res_pct, res_lin, res_gamma, res_last};

    scd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_wr),
        .i_wr_data (res_in),
        .i_rd      (pop),
        .o_rd_data (res_out),
        .o_empty   (empty),
        .o_full    (res_full),
        .o_count   ()
    );

    assign o_brightness_percent = res_out[RES_W-1 -: PCT_W];
    assign o_linear_duty        = res_out[2*DUTY_BITS : DUTY_BITS+1];
    assign o_gamma_duty         = res_out[DUTY_BITS : 1];
    assign o_last_of_run        = res_out[0];
endmodule

// ----- src/scd_fifo.sv -----
// scd_fifo: small synchronous queue with a register array and combinational head read.
// Depends on nothing; used for the command queue and the result queue.
module scd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd,
    output logic [WIDTH-1:0]           o_rd_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_wr, do_rd;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (do_wr && !do_rd) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_rd && !do_wr) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end
endmodule

// ----- src/scd_front.sv -----
// scd_front: accepts characters and ticks, keeps line and lockout state, issues commands.
// Depends on scd_pkg; feeds the command queue read by scd_back.
module scd_front #(
    parameter int MAX_LINE_CHARS = scd_pkg::DEF_MAX_LINE_CHARS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [scd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scd_pkg::CFG_W-1:0]       i_cfg_wdata,
    // items
    input  logic                            i_push,
    output logic                            o_full,
    input  logic                            i_operation,
    input  logic [scd_pkg::CHAR_W-1:0]      i_char_code,
    input  logic                            i_up_pressed,
    input  logic                            i_down_pressed,
    // command queue
    input  logic                            i_cmd_room2,
    output logic                            o_cmd_wr,
    output scd_pkg::t_cmd                   o_cmd
);
    import scd_pkg::*;

    localparam int LW = $clog2(MAX_LINE_CHARS + 1);

    logic [STEP_W-1:0] r_serial_step, r_button_step;
    logic [LOCK_W-1:0] r_lockout;
    logic [LW-1:0]     r_line_len, n_line_len;
    logic [CHAR_W-1:0] r_first_char, n_first_char;
    logic [PCT_W-1:0]  r_digit_val, n_digit_val;
    logic              r_digits_run, n_digits_run;
    logic [LOCK_W-1:0] r_since, n_since;
    logic              r_pend;
    t_cmd              r_pend_cmd;

    logic              accept;
    logic              is_eol, is_dig, first_dig;
    logic [CHAR_W-1:0] fold;
    logic [3:0]        dig;
    logic [9:0]        dig_ext;
    logic [LOCK_W-1:0] since_inc;
    logic              gate, up_go, dn_go;
    t_cmd              line_cmd, up_cmd, dn_cmd;
    logic              item_wr;
    t_cmd              item_cmd;

    assign o_full = r_pend || !i_cmd_room2;
    assign accept = i_push && !o_full;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial_step <= SERIAL_STEP_RST;
            r_button_step <= BUTTON_STEP_RST;
            r_lockout     <= LOCKOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SERIAL_STEP: r_serial_step <= i_cfg_wdata[STEP_W-1:0];
                CFG_BUTTON_STEP: r_button_step <= i_cfg_wdata[STEP_W-1:0];
                CFG_LOCKOUT_MS:  r_lockout     <= i_cfg_wdata[LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    // Character classification
    assign is_eol    = (i_char_code == CH_LF) || (i_char_code == CH_CR);
    assign is_dig    = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign dig       = 4'(i_char_code - CH_ZERO);
    assign dig_ext   = 10'(r_digit_val) * 10'd10 + 10'(dig);
    assign fold      = r_first_char | CH_CASE;
    assign first_dig = (r_first_char >= CH_ZERO) && (r_first_char <= CH_NINE);

    // Command for a completed line
    always_comb begin
        line_cmd.last   = 1'b1;
        line_cmd.op     = CMD_KEEP;
        line_cmd.amount = '0;
        if (fold == CH_LOW_U) begin
            line_cmd.op     = CMD_ADD;
            line_cmd.amount = r_serial_step;
        end else if (fold == CH_LOW_D) begin
            line_cmd.op     = CMD_SUB;
            line_cmd.amount = r_serial_step;
        end else if (fold == CH_LOW_M) begin
            line_cmd.op     = CMD_SET;
            line_cmd.amount = PCT_MAX;
        end else if (fold == CH_LOW_N) begin
            line_cmd.op     = CMD_SET;
            line_cmd.amount = '0;
        end else if (first_dig) begin
            line_cmd.op     = CMD_SET;
            line_cmd.amount = (r_digit_val > PCT_MAX) ? PCT_MAX : r_digit_val;
        end
    end

    // Button gate, evaluated once per tick
    assign since_inc = (r_since < SINCE_SAT) ? LOCK_W'(r_since + 1'b1) : r_since;
    assign gate      = since_inc > r_lockout;
    assign up_go     = gate && i_up_pressed;
    assign dn_go     = gate && i_down_pressed;

    always_comb begin
        up_cmd.op     = CMD_ADD;
        up_cmd.amount = r_button_step;
        up_cmd.last   = !dn_go;
        dn_cmd.op     = CMD_SUB;
        dn_cmd.amount = r_button_step;
        dn_cmd.last   = 1'b1;
    end

    // Next line / lockout state and command of the accepted item
    always_comb begin
        n_line_len   = r_line_len;
        n_first_char = r_first_char;
        n_digit_val  = r_digit_val;
        n_digits_run = r_digits_run;
        n_since      = r_since;
        item_wr      = 1'b0;
        item_cmd     = line_cmd;
        if (!i_operation) begin
            if (is_eol) begin
                if (r_line_len != '0) begin
                    item_wr      = 1'b1;
                    n_line_len   = '0;
                    n_first_char = '0;
                    n_digit_val  = '0;
                    n_digits_run = 1'b0;
                end
            end else if (r_line_len < LW'(MAX_LINE_CHARS)) begin
                n_line_len = LW'(r_line_len + 1'b1);
                if (r_line_len == '0) begin
                    n_first_char = i_char_code;
                    n_digits_run = is_dig;
                    n_digit_val  = is_dig ? PCT_W'(dig) : '0;
                end else if (r_digits_run) begin
                    if (is_dig) begin
                        n_digit_val = (dig_ext > 10'(DIGIT_SAT)) ? DIGIT_SAT
                                                                 : PCT_W'(dig_ext);
                    end else begin
                        n_digits_run = 1'b0;
                    end
                end
            end
        end else begin
            n_since = (up_go || dn_go) ? '0 : since_inc;
            if (up_go) begin
                item_wr  = 1'b1;
                item_cmd = up_cmd;
            end else if (dn_go) begin
                item_wr  = 1'b1;
                item_cmd = dn_cmd;
            end
        end
    end

    // Command queue write: a held second press goes first
    assign o_cmd_wr = r_pend || (accept && item_wr);
    assign o_cmd    = r_pend ? r_pend_cmd : item_cmd;

    always_ff @(posedge i_clk) begin
        r_pend_cmd <= dn_cmd;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len   <= '0;
            r_first_char <= '0;
            r_digit_val  <= '0;
            r_digits_run <= 1'b0;
            r_since      <= '0;
            r_pend       <= 1'b0;
        end else begin
            r_pend <= accept && i_operation && up_go && dn_go;
            if (accept) begin
                r_line_len   <= n_line_len;
                r_first_char <= n_first_char;
                r_digit_val  <= n_digit_val;
                r_digits_run <= n_digits_run;
                r_since      <= n_since;
            end
        end
    end
endmodule

// ----- src/scd_back.sv -----
// scd_back: applies commands to the brightness level and forms duty results.
// Depends on scd_pkg; reads the command queue, writes the result queue.
module scd_back #(
    parameter int DUTY_BITS = scd_pkg::DEF_DUTY_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command queue
    input  logic                         i_cmd_empty,
    input  scd_pkg::t_cmd                i_cmd,
    output logic                         o_cmd_rd,
    // result queue
    input  logic                         i_res_full,
    output logic                         o_res_wr,
    output logic [scd_pkg::PCT_W-1:0]    o_pct,
    output logic [DUTY_BITS-1:0]         o_lin,
    output logic [DUTY_BITS-1:0]         o_gamma,
    output logic                         o_last
);
    import scd_pkg::*;

    localparam int unsigned DUTY_MAX = (1 << DUTY_BITS) - 1;

    logic [PCT_W-1:0]     r_level, n_level;
    logic                 r_stg_vld, r_stg_last;
    logic [PCT_W:0]       sum;
    logic [DUTY_BITS-1:0] lin_tab   [0:PCT_ENTRIES-1];
    logic [DUTY_BITS-1:0] gamma_tab [0:PCT_ENTRIES-1];

    // Duty tables, scaled at elaboration
    for (genvar g = 0; g < PCT_ENTRIES; g++) begin : g_tab
        localparam int unsigned LV = (g * DUTY_MAX) / 100;
        localparam int unsigned GV = (int'(GAMMA_ROM[g]) * DUTY_MAX) / GAMMA_SCALE;
        assign lin_tab[g]   = LV[DUTY_BITS-1:0];
        assign gamma_tab[g] = GV[DUTY_BITS-1:0];
    end

    // Handshakes: the stage moves on when the result queue has room
    assign o_res_wr = r_stg_vld && !i_res_full;
    assign o_cmd_rd = !i_cmd_empty && (!r_stg_vld || o_res_wr);

    // Level update with clamping to 0..100
    assign sum = (PCT_W + 1)'(r_level) + (PCT_W + 1)'(i_cmd.amount);
    always_comb begin
        case (i_cmd.op)
            CMD_ADD: n_level = (sum > (PCT_W + 1)'(PCT_MAX)) ? PCT_MAX : PCT_W'(sum);
            CMD_SUB: n_level = (r_level < i_cmd.amount) ? '0 : PCT_W'(r_level - i_cmd.amount);
            CMD_SET: n_level = i_cmd.amount;
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= LEVEL_RST;
            r_stg_vld  <= 1'b0;
            r_stg_last <= 1'b0;
        end else if (o_cmd_rd) begin
            r_level    <= n_level;
            r_stg_vld  <= 1'b1;
            r_stg_last <= i_cmd.last;
        end else if (o_res_wr) begin
            r_stg_vld  <= 1'b0;
        end
    end

    // Result fields from the registered level
    assign o_pct   = r_level;
    assign o_lin   = lin_tab[r_level];
    assign o_gamma = gamma_tab[r_level];
    assign o_last  = r_stg_last;
endmodule

// ----- dv/serial_command_led_dimmer_top_test.sv -----
`timescale 1ns / 1ps
// serial_command_led_dimmer_top_test: self-checking bench for the serial/button LED dimmer.
// Depends on scd_pkg and serial_command_led_dimmer_top; keeps its own dimmer model and
// checks every popped result against it.
module serial_command_led_dimmer_top_test;
    import scd_pkg::*;

    localparam bit OP_CHAR = 1'b0;
    localparam bit OP_TICK = 1'b1;
    localparam int LINE_CAP = DEF_MAX_LINE_CHARS;
    localparam int DUTY_FULL = 1023;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [9:0]       lin;
        logic [9:0]       gam;
        logic             last;
    } t_level_report;

    // floor((p/100)^2.2 * 1023) for p = 0..100
    localparam logic [9:0] GAMMA_CURVE [0:100] = '{
        0, 0, 0, 0, 0, 1, 2, 2, 3, 5,
        6, 7, 9, 11, 13, 15, 18, 20, 23, 26,
        29, 33, 36, 40, 44, 48, 52, 57, 62, 67,
        72, 77, 83, 89, 95, 101, 108, 114, 121, 128,
        136, 143, 151, 159, 168, 176, 185, 194, 203, 212,
        222, 232, 242, 253, 263, 274, 285, 297, 308, 320,
        332, 344, 357, 370, 383, 396, 410, 423, 437, 452,
        466, 481, 496, 511, 527, 543, 559, 575, 592, 609,
        626, 643, 661, 678, 697, 715, 734, 753, 772, 791,
        811, 831, 851, 872, 892, 913, 935, 956, 978, 1000,
        1023
    };

    // DUT ports, all inputs known from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_SERIAL_STEP;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 i_operation = OP_CHAR;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic                 i_up_pressed = 1'b0;
    logic                 i_down_pressed = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [PCT_W-1:0]     o_brightness_percent;
    logic [9:0]           o_linear_duty;
    logic [9:0]           o_gamma_duty;
    logic                 o_last_of_run;

    // Dimmer model state and registers
    logic [STEP_W-1:0] serial_step_q;
    logic [STEP_W-1:0] button_step_q;
    logic [LOCK_W-1:0] lockout_q;
    logic [PCT_W-1:0]  level_q;
    int unsigned       line_len_q;
    logic [CHAR_W-1:0] first_char_q;
    int unsigned       digit_val_q;
    bit                digits_on_q;
    int unsigned       since_ms_q;
    t_level_report     level_reports_due[$];

    // Bookkeeping
    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 74;
    int unsigned items_sent = 0;
    int unsigned items_taken = 0;
    int unsigned ticks_taken = 0;
    int unsigned reports_seen = 0;
    int unsigned register_loads = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;

    serial_command_led_dimmer_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .push                 (push),
        .full                 (full),
        .i_operation          (i_operation),
        .i_char_code          (i_char_code),
        .i_up_pressed         (i_up_pressed),
        .i_down_pressed       (i_down_pressed),
        .empty                (empty),
        .pop                  (pop),
        .o_brightness_percent (o_brightness_percent),
        .o_linear_duty        (o_linear_duty),
        .o_gamma_duty         (o_gamma_duty),
        .o_last_of_run        (o_last_of_run)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [PCT_W-1:0] clamp_pct(int v);
        if (v < 0) return '0;
        if (v > 100) return PCT_MAX;
        return PCT_W'(v);
    endfunction

    function automatic bit is_digit(logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_level_report report_for(logic [PCT_W-1:0] pct);
        t_level_report r;
        r.pct  = pct;
        r.lin  = 10'((int'(pct) * DUTY_FULL) / 100);
        r.gam  = GAMMA_CURVE[pct];
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void reset_dimmer_model();
        serial_step_q = SERIAL_STEP_RST;
        button_step_q = BUTTON_STEP_RST;
        lockout_q     = LOCKOUT_RST;
        level_q       = LEVEL_RST;
        since_ms_q    = 0;
        line_len_q    = 0;
        first_char_q  = '0;
        digit_val_q   = 0;
        digits_on_q   = 1'b0;
    endfunction

    // Apply one accepted item to the model and queue the results it causes
    function automatic void compute_dimmer_reports(bit op, logic [CHAR_W-1:0] ch,
                                                   bit up, bit dn);
        t_level_report fresh[2];
        int n;
        n = 0;
        if (op == OP_CHAR) begin
            if (ch == CH_CR || ch == CH_LF) begin
                if (line_len_q != 0) begin
                    case (first_char_q)
                        "u", "U": level_q = clamp_pct(int'(level_q) + int'(serial_step_q));
                        "d", "D": level_q = clamp_pct(int'(level_q) - int'(serial_step_q));
                        "m", "M": level_q = PCT_MAX;
                        "n", "N": level_q = '0;
                        default: begin
                            if (is_digit(first_char_q))
                                level_q = (digit_val_q > 100) ? PCT_MAX : PCT_W'(digit_val_q);
                        end
                    endcase
                    fresh[n++] = report_for(level_q);
                    line_len_q   = 0;
                    first_char_q = '0;
                    digit_val_q  = 0;
                    digits_on_q  = 1'b0;
                end
            end else if (line_len_q < LINE_CAP) begin
                if (line_len_q == 0) begin
                    first_char_q = ch;
                    digits_on_q  = is_digit(ch);
                    digit_val_q  = digits_on_q ? int'(ch) - int'(CH_ZERO) : 0;
                end else if (digits_on_q) begin
                    if (is_digit(ch)) begin
                        digit_val_q = digit_val_q * 10 + (int'(ch) - int'(CH_ZERO));
                        if (digit_val_q > DIGIT_SAT) digit_val_q = DIGIT_SAT;
                    end else begin
                        digits_on_q = 1'b0;
                    end
                end
                line_len_q++;
            end
        end else begin
            // lockout gate is evaluated once; up is applied before down
            if (since_ms_q < SINCE_SAT) since_ms_q++;
            if (since_ms_q > lockout_q) begin
                if (up) begin
                    level_q = clamp_pct(int'(level_q) + int'(button_step_q));
                    fresh[n++] = report_for(level_q);
                    since_ms_q = 0;
                end
                if (dn) begin
                    level_q = clamp_pct(int'(level_q) - int'(button_step_q));
                    fresh[n++] = report_for(level_q);
                    since_ms_q = 0;
                end
            end
        end
        if (n > 0) fresh[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) level_reports_due.push_back(fresh[i]);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Register writes, accepted items and popped results, all sampled at the edge
    always @(posedge i_clk) begin : watch_transfers
        t_level_report due;
        if (!i_rst_n) begin
            reset_dimmer_model();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SERIAL_STEP: serial_step_q = i_cfg_wdata[STEP_W-1:0];
                    CFG_BUTTON_STEP: button_step_q = i_cfg_wdata[STEP_W-1:0];
                    CFG_LOCKOUT_MS:  lockout_q     = i_cfg_wdata[LOCK_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                items_taken++;
                if (i_operation == OP_TICK) ticks_taken++;
                compute_dimmer_reports(i_operation, i_char_code, i_up_pressed, i_down_pressed);
            end
            if (pop && !empty) begin
                reports_seen++;
                if (level_reports_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual pct %0d",
                             $time, o_brightness_percent);
                end else begin
                    due = level_reports_due.pop_front();
                    check_field("brightness_percent", due.pct, o_brightness_percent);
                    check_field("linear_duty", due.lin, o_linear_duty);
                    check_field("gamma_duty", due.gam, o_gamma_duty);
                    check_field("last_of_run", due.last, o_last_of_run);
                end
            end
        end
    end

    // Result side: random pop stalls
    always @(posedge i_clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // One item transfer; push stays high for a following item
    task automatic send_item(bit op, logic [CHAR_W-1:0] ch, bit up, bit dn);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_operation    <= op;
        i_char_code    <= ch;
        i_up_pressed   <= up;
        i_down_pressed <= dn;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    // Characters carry random button bits, which the block must ignore
    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++)
            send_item(OP_CHAR, text[i], 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic send_line(string text, logic [CHAR_W-1:0] term);
        send_text(text);
        send_item(OP_CHAR, term, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Ticks carry a random byte, which the block must ignore
    task automatic send_tick(bit up, bit dn);
        send_item(OP_TICK, CHAR_W'($urandom_range(255)), up, dn);
    endtask

    // Stop sending, wait for every expected result, then let the pipeline settle
    task automatic wait_until_quiet();
        push <= 1'b0;
        do @(negedge i_clk); while (level_reports_due.size() != 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_registers(int unsigned s_step, int unsigned b_step, int unsigned lock);
        wait_until_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_SERIAL_STEP;
        i_cfg_wdata <= CFG_W'(s_step);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_BUTTON_STEP;
        i_cfg_wdata <= CFG_W'(b_step);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_LOCKOUT_MS;
        i_cfg_wdata <= CFG_W'(lock);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        register_loads++;
    endtask

    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(255)); while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic int unsigned pick_step();
        case ($urandom_range(5))
            0: return 0;
            1: return 100;
            2: return 127;
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    function automatic int unsigned pick_lockout();
        case ($urandom_range(9))
            0: return 0;
            1: return 1000;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Well-formed command line with random lead, body and terminator
    task automatic send_random_line();
        string cmds;
        logic [CHAR_W-1:0] lead;
        int unsigned body;
        cmds = "uUdDmMnN";
        case ($urandom_range(3))
            0, 1: lead = cmds[$urandom_range(7)];
            2: lead = CH_ZERO + CHAR_W'($urandom_range(9));
            default: lead = text_byte();
        endcase
        body = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
        send_item(OP_CHAR, lead, 1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (body)
            send_item(OP_CHAR,
                      ($urandom_range(2) != 0) ? CH_ZERO + CHAR_W'($urandom_range(9))
                                               : text_byte(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        send_item(OP_CHAR, $urandom_range(1) ? CH_CR : CH_LF,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Reset values: serial step of 10, empty line gives nothing
    task automatic test_reset_defaults();
        send_line("u", CH_CR);
        send_item(OP_CHAR, CH_LF, 1'b0, 1'b0);
        send_line("d", CH_LF);
    endtask

    // Default lockout of 200 ms: the 201st tick lets both buttons act, up first
    task automatic test_button_lockout();
        repeat (200) send_tick(1'b1, 1'($urandom_range(1)));
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
    endtask

    // Each command class, digit overflow, broken digit run, unknown lead
    task automatic test_line_commands();
        send_line("M", CH_CR);
        send_line("250", CH_LF);
        send_line("N", CH_CR);
        send_line("U", CH_LF);
        send_line("7x5", CH_CR);
        send_line("D", CH_LF);
        send_line("?", CH_CR);
    endtask

    // Bytes past the line cap are dropped, so the lead stays 'd'
    task automatic test_long_line();
        send_line("dkkkkkkkkkkkkkkMn", CH_CR);
    endtask

    // A CR on a tick must not end the line; buttons on characters do nothing
    task automatic test_ignored_fields();
        send_item(OP_CHAR, "m", 1'b1, 1'b1);
        send_item(OP_TICK, CH_CR, 1'b0, 1'b0);
        send_item(OP_CHAR, CH_CR, 1'b1, 1'b1);
    endtask

    // Steps above 100, zero steps, shortest and longest lockouts
    task automatic test_register_extremes();
        load_registers(127, 127, 0);
        send_line("u", CH_CR);
        send_tick(1'b1, 1'b1);
        send_line("D", CH_LF);
        load_registers(0, 0, 1);
        send_line("U", CH_CR);
        repeat (3) send_tick(1'b1, 1'b0);
        load_registers(1, 1, 1023);
        repeat (40) send_tick(1'b1, 1'b1);
        send_line("m", CH_CR);
    endtask

    // Mostly command lines, with tick bursts and stray bytes; new registers every third
    task automatic test_random_traffic(int unsigned count);
        int unsigned stop_at;
        repeat (3) begin
            load_registers(pick_step(), pick_step(), pick_lockout());
            stop_at = items_sent + count / 3;
            while (items_sent < stop_at) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: send_random_line();
                    6, 7, 8:
                        repeat ($urandom_range(1, 6))
                            send_tick($urandom_range(2) == 0, $urandom_range(3) == 0);
                    default: send_item(OP_CHAR, CHAR_W'($urandom_range(255)),
                                       1'($urandom_range(1)), 1'($urandom_range(1)));
                endcase
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_button_lockout();
        test_line_commands();
        test_long_line();
        test_ignored_fields();
        test_register_extremes();
        test_random_traffic(PHASE_ITEMS);

        wait_until_quiet();
        send_idle_pct = 74;
        recv_idle_pct = 17;
        test_random_traffic(PHASE_ITEMS);

        wait_until_quiet();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(PHASE_ITEMS);

        wait_until_quiet();
        $display("Run covered %0d items (%0d ticks) and %0d results over %0d register loads,",
                 items_taken, ticks_taken, reports_seen, register_loads);
        $display("with sender-heavy, receiver-heavy and stall-free traffic; %0d errors.",
                 fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
